FILE: rtl/core/mpb_pkg.sv
// mpb_pkg: shared types, constants and fixed-point helpers for magnetic_pendulum_basin.
// Used by mpb_rootdiv, mpb_dp, mpb_ctrl and the top level. No dependencies.
`default_nettype none

package mpb_pkg;

  localparam int QW = 28;
  localparam int QF = 20;
  localparam int NUM_REGS = 6;

  typedef logic signed [QW-1:0] q_t;

  localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};

  localparam q_t C_DT     = 28'sd104858;
  localparam q_t C_FRIC   = 28'sd230687;
  localparam q_t C_K      = 28'sd314573;
  localparam q_t C_SOFT   = 28'sd230687;
  localparam q_t C_SPEED2 = 28'sd20972;
  localparam q_t C_NEAR2  = 28'sd94372;

  typedef enum logic [2:0] {
    REG_A_X = 3'd0,
    REG_A_Y = 3'd1,
    REG_B_X = 3'd2,
    REG_B_Y = 3'd3,
    REG_C_X = 3'd4,
    REG_C_Y = 3'd5
  } reg_idx_t;

  localparam logic [NUM_REGS-1:0][15:0] CFG_RESET = {
    16'hF011, 16'hF6CD, 16'h0FEF, 16'hF6CD, 16'h0000, 16'h1266
  };

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_MUL, OP_ADD, OP_SUB, OP_NSUB,
    OP_LT, OP_KEEP, OP_MARK, OP_RECIP
  } op_t;

  typedef enum logic [4:0] {
    SRC_X, SRC_Y, SRC_VX, SRC_VY, SRC_AX, SRC_AY, SRC_DX, SRC_DY,
    SRC_T, SRC_U, SRC_D2, SRC_INV, SRC_MX, SRC_MY,
    SRC_K, SRC_FRIC, SRC_DT, SRC_SOFT, SRC_SPEED2, SRC_NEAR2
  } src_t;

  typedef enum logic [3:0] {
    DST_X, DST_Y, DST_VX, DST_VY, DST_AX, DST_AY, DST_DX, DST_DY,
    DST_T, DST_U, DST_D2
  } dst_t;

  typedef struct packed {
    op_t        op;
    src_t       a;
    src_t       b;
    dst_t       dst;
    logic [1:0] mag;
  } dp_cmd_t;

  typedef struct packed {
    logic       lt;
    logic       recip_done;
    logic [1:0] best;
  } dp_stat_t;

  function automatic q_t sat57(logic signed [56:0] v);
    if (v > 57'sd134217727) begin
      return Q_MAX;
    end else if (v < -57'sd134217728) begin
      return Q_MIN;
    end
    return q_t'(v[QW-1:0]);
  endfunction

  // Q20 x Q20 -> Q20, round half up, saturate
  function automatic q_t qmul(q_t a, q_t b);
    logic signed [56:0] p;
    p = 57'(a) * 57'(b) + 57'sd524288;
    p = p >>> QF;
    return sat57(p);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/magnetic_pendulum_basin.sv
// magnetic_pendulum_basin: top level, magnet registers, result register.
// Instantiates mpb_ctrl and mpb_dp; uses mpb_pkg.
//
// channel  dir  signals                                   transaction
// in       in   in_valid/in_ready, in_start_x, in_start_y  one bob start position
// out      out  out_valid/out_ready, out_magnet_index      one magnet index
// cfg      in   cfg_valid/cfg_ready, cfg_index, cfg_data   one register write
//
// Per integration step the reciprocal root unit (root, multiply, quotient, then a done
// report) dominates. An item takes up to STEP_LIMIT steps plus a final nearest-magnet
// pass and a handoff through the done and idle states; a slow step adds a nearness
// check of each magnet, which can end the item early.
// Reset loads the magnet defaults. A waiting result does not block the next input.
`default_nettype none

module magnetic_pendulum_basin #(
  parameter int STEP_LIMIT    = 220,
  parameter int FRACTION_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_magnet_index,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import mpb_pkg::*;

  logic [NUM_REGS-1:0][15:0] cfg_r;
  logic                      out_valid_r;
  logic [1:0]                out_idx_r;
  logic                      out_free;
  logic                      done;
  dp_cmd_t                   cmd;
  dp_stat_t                  stat;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_index <= REG_C_Y) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_idx_r <= stat.best;
    end
  end

  mpb_ctrl #(
    .STEP_LIMIT (STEP_LIMIT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .done     (done),
    .cmd      (cmd),
    .stat     (stat)
  );

  mpb_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .start_x (in_start_x),
    .start_y (in_start_y),
    .mag_cfg (cfg_r),
    .stat    (stat)
  );

  assign out_valid        = out_valid_r;
  assign out_magnet_index = out_idx_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(done))
    else $error("result appeared without completion");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_idx_r != 2'd3)
    else $error("magnet index out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/mpb_rootdiv.sv
// mpb_rootdiv: iterative unit computing floor(2^60 / (D * floor(sqrt(D * 2^20)))).
// One root bit per cycle, one multiply, one quotient bit per cycle. Uses mpb_pkg.
`default_nettype none

module mpb_rootdiv (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  mpb_pkg::q_t   d2,
  output logic          done,
  output mpb_pkg::q_t   inv
);
  import mpb_pkg::*;

  localparam int NW = 48;
  localparam int DW = 51;
  localparam int RW = 52;
  localparam int QB = 25;
  localparam int ROOT_ITERS = 24;

  typedef enum logic [3:0] {
    RD_IDLE = 4'b0001,
    RD_SQRT = 4'b0010,
    RD_MUL  = 4'b0100,
    RD_DIV  = 4'b1000
  } rd_state_t;

  rd_state_t      state_r;
  logic [4:0]     cnt_r;
  logic [26:0]    d2_r;
  logic [NW-1:0]  n_r, res_r, bit_r;
  logic [DW-1:0]  den_r;
  logic [RW-1:0]  rem_r;
  logic [QB-1:0]  q_r;
  logic           done_r;

  logic [NW-1:0]  trial;
  logic [RW-1:0]  rem2;

  assign trial = res_r + bit_r;
  assign rem2  = {rem_r[RW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RD_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        RD_IDLE: begin
          if (start) begin
            state_r <= RD_SQRT;
            cnt_r   <= '0;
          end
        end
        RD_SQRT: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(ROOT_ITERS - 1)) begin
            state_r <= RD_MUL;
          end
        end
        RD_MUL: begin
          state_r <= RD_DIV;
          cnt_r   <= '0;
        end
        RD_DIV: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(QB - 1)) begin
            state_r <= RD_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= RD_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      RD_IDLE: begin
        if (start) begin
          d2_r  <= d2[26:0];
          n_r   <= {1'b0, d2[26:0], 20'd0};
          res_r <= '0;
          bit_r <= NW'(1) << (NW - 2);
        end
      end
      RD_SQRT: begin
        if (n_r >= trial) begin
          n_r   <= n_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      RD_MUL: begin
        den_r <= DW'(d2_r) * DW'(res_r[ROOT_ITERS-1:0]);
        rem_r <= RW'(1) << (60 - QB);
        q_r   <= '0;
      end
      RD_DIV: begin
        if (rem2 >= {1'b0, den_r}) begin
          rem_r <= rem2 - {1'b0, den_r};
          q_r   <= {q_r[QB-2:0], 1'b1};
        end else begin
          rem_r <= rem2;
          q_r   <= {q_r[QB-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign inv  = q_t'({{(QW-QB){1'b0}}, q_r});

endmodule

`default_nettype wire

FILE: rtl/core/mpb_dp.sv
// mpb_dp: fixed-point datapath, register file, shared multiplier and adder.
// Uses mpb_pkg and instantiates mpb_rootdiv for the magnet pull factor.
`default_nettype none

module mpb_dp #(
  parameter int FRACTION_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mpb_pkg::dp_cmd_t       cmd,
  input  logic signed [15:0]     start_x,
  input  logic signed [15:0]     start_y,
  input  logic [5:0][15:0]       mag_cfg,
  output mpb_pkg::dp_stat_t      stat
);
  import mpb_pkg::*;

  localparam int SH = QF - FRACTION_BITS;

  q_t x_r, y_r, vx_r, vy_r, ax_r, ay_r, dx_r, dy_r, t_r, u_r, d2_r, bd_r;
  logic       lt_r;
  logic [1:0] best_r;
  q_t         inv;
  logic       recip_done;
  q_t         opa, opb, res;

  function automatic q_t to_q20(logic [15:0] v);
    return q_t'({{(QW-16){v[15]}}, v}) <<< SH;
  endfunction

  function automatic q_t mag_q(logic [1:0] m, logic axis);
    logic [2:0] ri;
    ri = {m, axis};
    if (ri < 3'(NUM_REGS)) begin
      return to_q20(mag_cfg[ri]);
    end
    return '0;
  endfunction

  function automatic q_t sel(src_t s);
    case (s)
      SRC_X:      return x_r;
      SRC_Y:      return y_r;
      SRC_VX:     return vx_r;
      SRC_VY:     return vy_r;
      SRC_AX:     return ax_r;
      SRC_AY:     return ay_r;
      SRC_DX:     return dx_r;
      SRC_DY:     return dy_r;
      SRC_T:      return t_r;
      SRC_U:      return u_r;
      SRC_D2:     return d2_r;
      SRC_INV:    return inv;
      SRC_MX:     return mag_q(cmd.mag, 1'b0);
      SRC_MY:     return mag_q(cmd.mag, 1'b1);
      SRC_K:      return C_K;
      SRC_FRIC:   return C_FRIC;
      SRC_DT:     return C_DT;
      SRC_SOFT:   return C_SOFT;
      SRC_SPEED2: return C_SPEED2;
      SRC_NEAR2:  return C_NEAR2;
      default:    return '0;
    endcase
  endfunction

  assign opa = sel(cmd.a);
  assign opb = sel(cmd.b);

  always_comb begin
    case (cmd.op)
      OP_MUL:  res = qmul(opa, opb);
      OP_ADD:  res = sat57(57'(opa) + 57'(opb));
      OP_SUB:  res = sat57(57'(opa) - 57'(opb));
      OP_NSUB: res = sat57(-57'(opa) - 57'(opb));
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x_r  <= to_q20(start_x);
        y_r  <= to_q20(start_y);
        vx_r <= '0;
        vy_r <= '0;
      end
      OP_MUL, OP_ADD, OP_SUB, OP_NSUB: begin
        case (cmd.dst)
          DST_X:   x_r  <= res;
          DST_Y:   y_r  <= res;
          DST_VX:  vx_r <= res;
          DST_VY:  vy_r <= res;
          DST_AX:  ax_r <= res;
          DST_AY:  ay_r <= res;
          DST_DX:  dx_r <= res;
          DST_DY:  dy_r <= res;
          DST_T:   t_r  <= res;
          DST_U:   u_r  <= res;
          DST_D2:  d2_r <= res;
          default: ;
        endcase
      end
      OP_KEEP: begin
        if (cmd.mag == 2'd0 || d2_r < bd_r) begin
          bd_r <= d2_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r   <= 1'b0;
      best_r <= '0;
    end else begin
      case (cmd.op)
        OP_LT:   lt_r <= opa < opb;
        OP_KEEP: begin
          if (cmd.mag == 2'd0 || d2_r < bd_r) begin
            best_r <= cmd.mag;
          end
        end
        OP_MARK: best_r <= cmd.mag;
        default: ;
      endcase
    end
  end

  mpb_rootdiv u_rootdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_RECIP),
    .d2    (d2_r),
    .done  (recip_done),
    .inv   (inv)
  );

  assign stat.lt         = lt_r;
  assign stat.recip_done = recip_done;
  assign stat.best       = best_r;

endmodule

`default_nettype wire

FILE: rtl/core/mpb_ctrl.sv
// mpb_ctrl: sequencer issuing datapath commands for each integration step.
// Uses mpb_pkg; drives mpb_dp through dp_cmd_t and reads dp_stat_t.
`default_nettype none

module mpb_ctrl #(
  parameter int STEP_LIMIT = 220
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_free,
  output logic               done,
  output mpb_pkg::dp_cmd_t   cmd,
  input  mpb_pkg::dp_stat_t  stat
);
  import mpb_pkg::*;

  localparam int SW = $clog2(STEP_LIMIT + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_ACC   = 10'b0000000010,
    S_MAG   = 10'b0000000100,
    S_WAIT  = 10'b0000001000,
    S_FORCE = 10'b0000010000,
    S_UPD   = 10'b0000100000,
    S_SPD   = 10'b0001000000,
    S_NEAR  = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t         state_r, state_nxt;
  logic [2:0]     pc_r, pc_nxt;
  logic [1:0]     mag_r, mag_nxt;
  logic [SW-1:0]  step_r, step_nxt;
  logic           last_step;

  assign last_step = step_r == SW'(STEP_LIMIT - 1);

  function automatic dp_cmd_t mk(op_t op, src_t a, src_t b, dst_t d, logic [1:0] m);
    dp_cmd_t c;
    c.op  = op;
    c.a   = a;
    c.b   = b;
    c.dst = d;
    c.mag = m;
    return c;
  endfunction

  // squared distance from bob to magnet m into D2, five commands
  function automatic dp_cmd_t dist_cmd(logic [2:0] pc, logic [1:0] m);
    case (pc)
      3'd0:    return mk(OP_SUB, SRC_MX, SRC_X, DST_DX, m);
      3'd1:    return mk(OP_SUB, SRC_MY, SRC_Y, DST_DY, m);
      3'd2:    return mk(OP_MUL, SRC_DX, SRC_DX, DST_T, m);
      3'd3:    return mk(OP_MUL, SRC_DY, SRC_DY, DST_U, m);
      3'd4:    return mk(OP_ADD, SRC_T, SRC_U, DST_D2, m);
      default: return mk(OP_NOP, SRC_X, SRC_X, DST_T, m);
    endcase
  endfunction

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r + 3'd1;
    mag_nxt   = mag_r;
    step_nxt  = step_r;
    cmd       = mk(OP_NOP, SRC_X, SRC_X, DST_T, mag_r);
    done      = 1'b0;
    case (state_r)
      S_IDLE: begin
        pc_nxt = '0;
        if (in_valid) begin
          cmd       = mk(OP_LOAD, SRC_X, SRC_X, DST_T, mag_r);
          step_nxt  = '0;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        case (pc_r)
          3'd0:    cmd = mk(OP_MUL, SRC_K, SRC_X, DST_T, mag_r);
          3'd1:    cmd = mk(OP_MUL, SRC_FRIC, SRC_VX, DST_U, mag_r);
          3'd2:    cmd = mk(OP_NSUB, SRC_T, SRC_U, DST_AX, mag_r);
          3'd3:    cmd = mk(OP_MUL, SRC_K, SRC_Y, DST_T, mag_r);
          3'd4:    cmd = mk(OP_MUL, SRC_FRIC, SRC_VY, DST_U, mag_r);
          default: cmd = mk(OP_NSUB, SRC_T, SRC_U, DST_AY, mag_r);
        endcase
        if (pc_r == 3'd5) begin
          state_nxt = S_MAG;
          pc_nxt    = '0;
          mag_nxt   = '0;
        end
      end
      S_MAG: begin
        if (pc_r == 3'd5) begin
          cmd = mk(OP_ADD, SRC_D2, SRC_SOFT, DST_D2, mag_r);
        end else if (pc_r == 3'd6) begin
          cmd       = mk(OP_RECIP, SRC_D2, SRC_D2, DST_T, mag_r);
          state_nxt = S_WAIT;
        end else begin
          cmd = dist_cmd(pc_r, mag_r);
        end
      end
      S_WAIT: begin
        pc_nxt = '0;
        if (stat.recip_done) begin
          state_nxt = S_FORCE;
        end
      end
      S_FORCE: begin
        case (pc_r)
          3'd0:    cmd = mk(OP_MUL, SRC_DX, SRC_INV, DST_T, mag_r);
          3'd1:    cmd = mk(OP_ADD, SRC_AX, SRC_T, DST_AX, mag_r);
          3'd2:    cmd = mk(OP_MUL, SRC_DY, SRC_INV, DST_T, mag_r);
          default: cmd = mk(OP_ADD, SRC_AY, SRC_T, DST_AY, mag_r);
        endcase
        if (pc_r == 3'd3) begin
          pc_nxt = '0;
          if (mag_r == 2'd2) begin
            state_nxt = S_UPD;
          end else begin
            mag_nxt   = mag_r + 2'd1;
            state_nxt = S_MAG;
          end
        end
      end
      S_UPD: begin
        case (pc_r)
          3'd0:    cmd = mk(OP_MUL, SRC_AX, SRC_DT, DST_T, mag_r);
          3'd1:    cmd = mk(OP_ADD, SRC_VX, SRC_T, DST_VX, mag_r);
          3'd2:    cmd = mk(OP_MUL, SRC_AY, SRC_DT, DST_T, mag_r);
          3'd3:    cmd = mk(OP_ADD, SRC_VY, SRC_T, DST_VY, mag_r);
          3'd4:    cmd = mk(OP_MUL, SRC_VX, SRC_DT, DST_T, mag_r);
          3'd5:    cmd = mk(OP_ADD, SRC_X, SRC_T, DST_X, mag_r);
          3'd6:    cmd = mk(OP_MUL, SRC_VY, SRC_DT, DST_T, mag_r);
          default: cmd = mk(OP_ADD, SRC_Y, SRC_T, DST_Y, mag_r);
        endcase
        if (pc_r == 3'd7) begin
          state_nxt = S_SPD;
          pc_nxt    = '0;
        end
      end
      S_SPD: begin
        case (pc_r)
          3'd0:    cmd = mk(OP_MUL, SRC_VX, SRC_VX, DST_T, mag_r);
          3'd1:    cmd = mk(OP_MUL, SRC_VY, SRC_VY, DST_U, mag_r);
          3'd2:    cmd = mk(OP_ADD, SRC_T, SRC_U, DST_D2, mag_r);
          3'd3:    cmd = mk(OP_LT, SRC_D2, SRC_SPEED2, DST_T, mag_r);
          default: ;
        endcase
        if (pc_r == 3'd4) begin
          pc_nxt = '0;
          if (stat.lt) begin
            state_nxt = S_NEAR;
            mag_nxt   = '0;
          end else if (last_step) begin
            state_nxt = S_FIN;
            mag_nxt   = '0;
          end else begin
            step_nxt  = step_r + SW'(1);
            state_nxt = S_ACC;
          end
        end
      end
      S_NEAR: begin
        if (pc_r == 3'd5) begin
          cmd = mk(OP_LT, SRC_D2, SRC_NEAR2, DST_T, mag_r);
        end else if (pc_r == 3'd6) begin
          pc_nxt = '0;
          if (stat.lt) begin
            cmd       = mk(OP_MARK, SRC_X, SRC_X, DST_T, mag_r);
            state_nxt = S_DONE;
          end else if (mag_r != 2'd2) begin
            mag_nxt = mag_r + 2'd1;
          end else if (last_step) begin
            state_nxt = S_FIN;
            mag_nxt   = '0;
          end else begin
            step_nxt  = step_r + SW'(1);
            state_nxt = S_ACC;
          end
        end else begin
          cmd = dist_cmd(pc_r, mag_r);
        end
      end
      S_FIN: begin
        if (pc_r == 3'd5) begin
          cmd    = mk(OP_KEEP, SRC_D2, SRC_D2, DST_T, mag_r);
          pc_nxt = '0;
          if (mag_r == 2'd2) begin
            state_nxt = S_DONE;
          end else begin
            mag_nxt = mag_r + 2'd1;
          end
        end else begin
          cmd = dist_cmd(pc_r, mag_r);
        end
      end
      S_DONE: begin
        pc_nxt = '0;
        if (out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        pc_nxt    = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      mag_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      mag_r   <= mag_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

endmodule

`default_nettype wire

FILE: test/tb_magnetic_pendulum_basin.sv
// tb_magnetic_pendulum_basin: self-checking testbench for magnetic_pendulum_basin.
// Drives start positions and magnet writes, predicts each basin index in fixed point.
// Depends on mpb_pkg and the magnetic_pendulum_basin RTL.
module tb_magnetic_pendulum_basin;
  import mpb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 220;
  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam longint QHI = 134217727;
  localparam longint QLO = -134217728;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_start_x = '0;
  logic signed [15:0] in_start_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_magnet_index;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic [15:0] magnet_regs [NUM_REGS];
  logic [1:0] basin_queue [$];
  int fails = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  longint cycles = 0;

  magnetic_pendulum_basin i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** magnetic_pendulum_basin: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (basin_queue.size() == 0) begin
        $display("%0t: unexpected result, actual %0d", $time, out_magnet_index);
        fails++;
      end else begin
        if (out_magnet_index !== basin_queue[0]) begin
          $display("%0t: magnet_index expected %0d actual %0d", $time, basin_queue[0],
                   out_magnet_index);
          fails++;
        end
        void'(basin_queue.pop_front());
      end
    end
  end

  function automatic longint clamp_q(longint v);
    if (v > QHI) return QHI;
    if (v < QLO) return QLO;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return clamp_q((a * b + 64'sd524288) >>> 20);
  endfunction

  function automatic longint sq_dist(longint dx, longint dy);
    return clamp_q(fx_mul(dx, dx) + fx_mul(dy, dy));
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint to_fix(logic [15:0] raw);
    return longint'($signed(raw)) * 256;
  endfunction

  function automatic logic [1:0] basin_of(logic [15:0] sx, logic [15:0] sy);
    longint mx [3], my [3];
    longint x, y, vx, vy, ax, ay, dx, dy, d2, inv, bd, d;
    longint unsigned root, den;
    int best;
    x = to_fix(sx);
    y = to_fix(sy);
    vx = 0;
    vy = 0;
    for (int i = 0; i < 3; i++) begin
      mx[i] = to_fix(magnet_regs[2*i]);
      my[i] = to_fix(magnet_regs[2*i+1]);
    end
    for (int s = 0; s < STEPS; s++) begin
      ax = clamp_q(-fx_mul(C_K, x) - fx_mul(C_FRIC, vx));
      ay = clamp_q(-fx_mul(C_K, y) - fx_mul(C_FRIC, vy));
      for (int i = 0; i < 3; i++) begin
        dx = clamp_q(mx[i] - x);
        dy = clamp_q(my[i] - y);
        d2 = clamp_q(sq_dist(dx, dy) + C_SOFT);
        root = int_root(longint'(d2) << 20);
        den = longint'(d2) * root;
        inv = clamp_q(longint'((64'd1 << 60) / den));
        ax = clamp_q(ax + fx_mul(dx, inv));
        ay = clamp_q(ay + fx_mul(dy, inv));
      end
      vx = clamp_q(vx + fx_mul(ax, C_DT));
      vy = clamp_q(vy + fx_mul(ay, C_DT));
      x = clamp_q(x + fx_mul(vx, C_DT));
      y = clamp_q(y + fx_mul(vy, C_DT));
      if (sq_dist(vx, vy) < C_SPEED2) begin
        for (int i = 0; i < 3; i++) begin
          if (sq_dist(clamp_q(mx[i] - x), clamp_q(my[i] - y)) < C_NEAR2) return 2'(i);
        end
      end
    end
    best = 0;
    bd = sq_dist(clamp_q(mx[0] - x), clamp_q(my[0] - y));
    for (int i = 1; i < 3; i++) begin
      d = sq_dist(clamp_q(mx[i] - x), clamp_q(my[i] - y));
      if (d < bd) begin
        bd = d;
        best = i;
      end
    end
    return 2'(best);
  endfunction

  task automatic send_start(logic [15:0] sx, logic [15:0] sy);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_x <= sx;
    in_start_y <= sy;
    do @(posedge clk); while (!in_ready);
    basin_queue.push_back(basin_of(sx, sy));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (basin_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_REGS) magnet_regs[idx] = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_magnets(logic [15:0] axv, logic [15:0] ayv, logic [15:0] bxv,
                               logic [15:0] byv, logic [15:0] cxv, logic [15:0] cyv);
    wait_drained();
    write_reg(REG_A_X, axv);
    write_reg(REG_A_Y, ayv);
    write_reg(REG_B_X, bxv);
    write_reg(REG_B_Y, byv);
    write_reg(REG_C_X, cxv);
    write_reg(REG_C_Y, cyv);
  endtask

  task automatic test_default_magnets();
    send_start(16'h0000, 16'h0000);
    send_start(16'h7FFF, 16'h7FFF);
    send_start(16'h8000, 16'h8000);
    send_start(16'h7FFF, 16'h8000);
    send_start(16'h8000, 16'h7FFF);
    send_start(16'd4710, 16'd0);
    send_start(-16'sd2355, 16'd4079);
    send_start(-16'sd2355, -16'sd4079);
    send_start(-16'sd12000, 16'd0);
    send_start(16'd1, 16'hFFFF);
  endtask

  task automatic test_extreme_magnets();
    write_magnets(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
    send_start(16'h0000, 16'h0000);
    send_start(16'h7FFF, 16'h7FFF);
    send_start(16'h8000, 16'h8000);
    // all magnets on one spot: lowest index must win
    write_magnets(16'd4096, 16'd0, 16'd4096, 16'd0, 16'd4096, 16'd0);
    send_start(16'd4096, 16'd0);
    send_start(-16'sd8000, 16'd3000);
  endtask

  task automatic test_unknown_index();
    wait_drained();
    write_reg(REG_SPARE_6, 16'h1234);
    write_reg(REG_SPARE_7, 16'hFFFF);
    send_start(16'd100, -16'sd200);
    write_magnets(CFG_RESET[0], CFG_RESET[1], CFG_RESET[2], CFG_RESET[3], CFG_RESET[4],
                  CFG_RESET[5]);
    send_start(16'd2000, 16'd2000);
  endtask

  task automatic test_random_traffic(int count, int tx_pct, int rx_pct, bit new_magnets);
    logic [15:0] sx, sy;
    if (new_magnets) begin
      write_magnets(16'($urandom_range(0, 24576) - 12288), 16'($urandom_range(0, 24576) - 12288),
                    16'($urandom_range(0, 24576) - 12288), 16'($urandom_range(0, 24576) - 12288),
                    16'($urandom_range(0, 24576) - 12288), 16'($urandom_range(0, 24576) - 12288));
    end
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 80) begin
        sx = 16'($urandom_range(0, 24576) - 12288);
        sy = 16'($urandom_range(0, 24576) - 12288);
      end else begin
        sx = 16'($urandom);
        sy = 16'($urandom);
      end
      if (i == count / 2) wait_drained();
      send_start(sx, sy);
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) magnet_regs[i] = CFG_RESET[i];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_magnets();
    test_extreme_magnets();
    test_unknown_index();
    test_random_traffic(34, 29, 55, 1'b0);
    test_random_traffic(33, 55, 29, 1'b1);
    test_random_traffic(33, 0, 0, 1'b1);
    wait_drained();
    repeat (300) @(posedge clk);
    if (fails == 0) begin
      $display("** magnetic_pendulum_basin: PASSED **");
    end else begin
      $display("** magnetic_pendulum_basin: FAILED **");
    end
    $finish;
  end

endmodule
